FILE: design/gaod_pkg.sv
package gaod_pkg;

    localparam int WIDTH_LIMIT  = 1024;
    localparam int HEIGHT_LIMIT = 1024;

    localparam int ALPHA_W   = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int ADDR_W = (WIDTH_LIMIT > 1) ? $clog2(WIDTH_LIMIT) : 1;
    localparam int COL_W  = $clog2(WIDTH_LIMIT + 2);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT + 2);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [ALPHA_W-1:0] alpha_in;
    } t_in;

    typedef struct packed {
        logic [ALPHA_W-1:0] gray_out;
        logic [ALPHA_W-1:0] outline_alpha;
        logic               frame_last;
    } t_out;

    typedef struct packed {
        logic               bank;
        logic               centre_ok;
        logic               north_ok;
        logic               south_ok;
        logic               east_ok;
        logic               west_ok;
        logic               last;
        logic [ALPHA_W-1:0] south;
    } t_slot;

    function automatic logic [COL_W-1:0] sat_width(logic [CFG_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v == '0) begin
            res = COL_W'(1);
        end else if (32'(v) > 32'(WIDTH_LIMIT)) begin
            res = COL_W'(WIDTH_LIMIT);
        end else begin
            res = COL_W'(v);
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] sat_height(logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v == '0) begin
            res = ROW_W'(1);
        end else if (32'(v) > 32'(HEIGHT_LIMIT)) begin
            res = ROW_W'(HEIGHT_LIMIT);
        end else begin
            res = ROW_W'(v);
        end
        return res;
    endfunction

endpackage

FILE: design/gaod_line_bank.sv
module gaod_line_bank
    import gaod_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr_a,
    input  logic [ADDR_W-1:0]  i_rd_addr_b,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [ALPHA_W-1:0] i_wr_data,
    output logic [ALPHA_W-1:0] o_rd_data_a,
    output logic [ALPHA_W-1:0] o_rd_data_b
);

    logic [ALPHA_W-1:0] mem [WIDTH_LIMIT];

    // A read and a write of the same entry in one cycle return the old value.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= mem[i_rd_addr_a];
            o_rd_data_b <= mem[i_rd_addr_b];
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

endmodule

FILE: design/glyph_alpha_outline_dilate.sv
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_stall      i_in_data (t_in)
// out       output     o_out_valid / i_out_stall    o_out_data (t_out)
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_stall is low; a pixel in the first or the last column of a
// row also issues an extra border output (both border outputs when the width is one), set by
// the single output slot per cycle that reads the two line stores.
// The first result of a request passes through the read stage (r_s1) and then the output
// register; each further result of the same request is issued from the pending state after it.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
// The input stalls while a further result of the previous pixel is still to be issued,
// or while the read stage and the output register are both full and the output stalls.
module glyph_alpha_outline_dilate
    import gaod_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in                  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready
);

    logic [COL_W-1:0]   r_eff_w, n_eff_w;
    logic [ROW_W-1:0]   r_eff_h, n_eff_h;
    logic [ROW_W-1:0]   r_in_row, n_in_row;
    logic [ADDR_W-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0]   r_out_row, n_out_row;
    logic [COL_W-1:0]   r_out_col, n_out_col;
    logic               r_pend_main, n_pend_main;
    logic               r_pend_right, n_pend_right;
    logic [ALPHA_W-1:0] r_pend_alpha, n_pend_alpha;
    logic               r_s1_valid, n_s1_valid;
    t_slot              r_s1, n_s1;
    logic [ALPHA_W-1:0] r_west, n_west;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    logic               s1_move, s1_free, pend, in_go, is_pix, is_drain;
    logic               issue, issue_main;
    logic [COL_W-1:0]   col_m1;
    logic [ADDR_W-1:0]  addr_a, addr_b;
    logic [ALPHA_W-1:0] wr_data;
    logic [ALPHA_W-1:0] rd_a0, rd_b0, rd_a1, rd_b1;
    logic [ALPHA_W-1:0] centre_raw, north_raw, east_raw;
    t_slot              slot;
    t_out               result;

    function automatic logic [ALPHA_W-1:0] amax(logic [ALPHA_W-1:0] a, logic [ALPHA_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign col_m1 = r_out_col - COL_W'(1);
    assign addr_a = col_m1[ADDR_W-1:0];
    assign addr_b = r_out_col[ADDR_W-1:0];
    assign wr_data = r_pend_main ? r_pend_alpha : i_in_data.alpha_in;

    gaod_line_bank u_bank0 (
        .i_clk       (i_clk),
        .i_rd_en     (issue),
        .i_rd_addr_a (addr_a),
        .i_rd_addr_b (addr_b),
        .i_wr_en     (issue_main && !r_out_row[0]),
        .i_wr_addr   (addr_a),
        .i_wr_data   (wr_data),
        .o_rd_data_a (rd_a0),
        .o_rd_data_b (rd_b0)
    );

    gaod_line_bank u_bank1 (
        .i_clk       (i_clk),
        .i_rd_en     (issue),
        .i_rd_addr_a (addr_a),
        .i_rd_addr_b (addr_b),
        .i_wr_en     (issue_main && r_out_row[0]),
        .i_wr_addr   (addr_a),
        .i_wr_data   (wr_data),
        .o_rd_data_a (rd_a1),
        .o_rd_data_b (rd_b1)
    );

    always_comb begin
        logic first_col, last_col, col_end, frame_end, in_cols, in_rows;
        logic [ALPHA_W-1:0] outl;

        s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
        s1_free    = !r_s1_valid || s1_move;
        pend       = r_pend_main || r_pend_right;
        o_in_stall = pend || !s1_free;
        in_go      = i_in_valid && !o_in_stall;
        is_pix     = in_go && (i_in_data.kind == KIND_PIXEL) && (r_in_row < r_eff_h);
        is_drain   = in_go && (i_in_data.kind == KIND_DRAIN) && (r_in_row >= r_eff_h);
        issue      = (pend && s1_free) || is_pix || is_drain;
        issue_main = (r_pend_main && s1_free) || (is_pix && (r_in_col != '0));

        first_col = (r_in_col == '0);
        last_col  = ((COL_W'(r_in_col) + COL_W'(1)) == r_eff_w);
        col_end   = (r_out_col == r_eff_w + COL_W'(1));
        frame_end = col_end && (r_out_row == r_eff_h + ROW_W'(1));

        in_cols = (r_out_col >= COL_W'(1)) && (r_out_col <= r_eff_w);
        in_rows = (r_out_row >= ROW_W'(1)) && (r_out_row <= r_eff_h);
        slot.bank      = r_out_row[0];
        slot.centre_ok = in_rows && in_cols;
        slot.north_ok  = (r_out_row >= ROW_W'(2)) && in_cols;
        slot.south_ok  = (r_out_row < r_eff_h) && in_cols;
        slot.east_ok   = in_rows && (r_out_col < r_eff_w);
        slot.west_ok   = in_rows && (r_out_col >= COL_W'(2));
        slot.last      = frame_end;
        slot.south     = wr_data;

        n_eff_w      = r_eff_w;
        n_eff_h      = r_eff_h;
        n_in_row     = r_in_row;
        n_in_col     = r_in_col;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_pend_main  = r_pend_main;
        n_pend_right = r_pend_right;
        n_pend_alpha = r_pend_alpha;

        if (issue) begin
            if (frame_end) begin
                n_out_row = '0;
                n_out_col = '0;
                n_in_row  = '0;
                n_in_col  = '0;
            end else if (col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end

        if (is_pix) begin
            if (last_col) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + ADDR_W'(1);
            end
            n_pend_main  = first_col;
            n_pend_right = last_col;
            n_pend_alpha = i_in_data.alpha_in;
        end else if (pend && s1_free) begin
            if (r_pend_main) begin
                n_pend_main = 1'b0;
            end else begin
                n_pend_right = 1'b0;
            end
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    n_eff_w = sat_width(i_cfg_data);
                end
                REG_IMAGE_HEIGHT: begin
                    n_eff_h = sat_height(i_cfg_data);
                end
                default: begin
                end
            endcase
            if (i_cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT}) begin
                n_in_row     = '0;
                n_in_col     = '0;
                n_out_row    = '0;
                n_out_col    = '0;
                n_pend_main  = 1'b0;
                n_pend_right = 1'b0;
            end
        end

        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (s1_free) begin
            n_s1_valid = issue;
            n_s1       = slot;
        end

        // The previous row sits in the bank opposite to the output row parity.
        centre_raw = r_s1.bank ? rd_a0 : rd_a1;
        north_raw  = r_s1.bank ? rd_a1 : rd_a0;
        east_raw   = r_s1.bank ? rd_b0 : rd_b1;

        result.gray_out = r_s1.centre_ok ? centre_raw : '0;
        outl = result.gray_out;
        outl = amax(outl, r_s1.north_ok ? north_raw : '0);
        outl = amax(outl, r_s1.south_ok ? r_s1.south : '0);
        outl = amax(outl, r_s1.east_ok ? east_raw : '0);
        outl = amax(outl, r_s1.west_ok ? r_west : '0);
        result.outline_alpha = outl;
        result.frame_last    = r_s1.last;

        n_west      = s1_move ? centre_raw : r_west;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (s1_move) begin
            n_out_valid = 1'b1;
            n_out       = result;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w      <= COL_W'(1);
            r_eff_h      <= ROW_W'(1);
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_pend_main  <= 1'b0;
            r_pend_right <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_eff_w      <= n_eff_w;
            r_eff_h      <= n_eff_h;
            r_in_row     <= n_in_row;
            r_in_col     <= n_in_col;
            r_out_row    <= n_out_row;
            r_out_col    <= n_out_col;
            r_pend_main  <= n_pend_main;
            r_pend_right <= n_pend_right;
            r_s1_valid   <= n_s1_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_alpha <= n_pend_alpha;
        r_s1         <= n_s1;
        r_west       <= n_west;
        r_out        <= n_out;
    end

endmodule

FILE: design/gaod_checker.sv
module gaod_checker
    import gaod_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output request changed or dropped.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_stall_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> o_out_valid)
        else $error("Input stalled with no work in flight.");

    a_last_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.frame_last
        |=> !(o_out_valid && !i_out_stall && o_out_data.frame_last))
        else $error("Two frame ends in consecutive requests.");

endmodule

bind glyph_alpha_outline_dilate gaod_checker u_gaod_checker (.*);

FILE: tb/sv/gaod_outline_checker.sv
module gaod_outline_checker
    import gaod_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int STORE_AW = $clog2(2 * WIDTH_LIMIT);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [ALPHA_W-1:0] row_store [2*WIDTH_LIMIT];
    int unsigned        src_row;
    int unsigned        src_col;
    int unsigned        dst_row;
    int unsigned        dst_col;
    t_out               outline_q[$];
    int                 mismatch_count = 0;
    int                 checked_count = 0;

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] raw,
                                               input int unsigned limit);
        int unsigned size;
        if (raw == '0) begin
            size = 1;
        end else if (int'(raw) > limit) begin
            size = limit;
        end else begin
            size = 32'(raw);
        end
        return size;
    endfunction

    function automatic logic [ALPHA_W-1:0] stored(input int unsigned row, input int unsigned col);
        return row_store[STORE_AW'((row & 1) * WIDTH_LIMIT + col)];
    endfunction

    function automatic logic [ALPHA_W-1:0] brighter(input logic [ALPHA_W-1:0] a,
                                                    input logic [ALPHA_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    task automatic restart_frame();
        src_row = 0;
        src_col = 0;
        dst_row = 0;
        dst_col = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Queues the next pixel of the enlarged frame; south is the incoming source pixel
    // below the centre when that one is being written in this request.
    task automatic predict_outline_pixel(input logic [ALPHA_W-1:0] south, output bit last);
        int unsigned        w;
        int unsigned        h;
        int unsigned        r;
        int unsigned        c;
        bit                 in_cols;
        bit                 in_rows;
        logic [ALPHA_W-1:0] centre;
        logic [ALPHA_W-1:0] outline;
        t_out               px;
        w = clamp_size(width_reg, WIDTH_LIMIT);
        h = clamp_size(height_reg, HEIGHT_LIMIT);
        r = dst_row;
        c = dst_col;
        in_cols = (c >= 1) && (c <= w);
        in_rows = (r >= 1) && (r <= h);
        centre = '0;
        if (in_rows && in_cols) begin
            centre = stored(r - 1, c - 1);
        end
        outline = centre;
        if (r >= 2 && in_cols) begin
            outline = brighter(outline, stored(r - 2, c - 1));
        end
        if (r + 1 <= h && in_cols) begin
            outline = brighter(outline, south);
        end
        if (in_rows && c + 1 <= w) begin
            outline = brighter(outline, stored(r - 1, c));
        end
        if (in_rows && c >= 2) begin
            outline = brighter(outline, stored(r - 1, c - 2));
        end
        last = (r == h + 1) && (c == w + 1);
        px.gray_out = centre;
        px.outline_alpha = outline;
        px.frame_last = last;
        outline_q = {outline_q, px};
        dst_col++;
        if (dst_col >= w + 2) begin
            dst_col = 0;
            dst_row++;
        end
    endtask

    task automatic predict_request(input t_in req);
        int unsigned w;
        int unsigned h;
        bit          last;
        w = clamp_size(width_reg, WIDTH_LIMIT);
        h = clamp_size(height_reg, HEIGHT_LIMIT);
        if (req.kind == KIND_DRAIN) begin
            if (src_row >= h) begin
                predict_outline_pixel('0, last);
                if (last) begin
                    restart_frame();
                end
            end
        end else if (src_row < h) begin
            if (src_col == 0) begin
                predict_outline_pixel('0, last);
            end
            predict_outline_pixel(req.alpha_in, last);
            if (src_col + 1 == w) begin
                predict_outline_pixel('0, last);
            end
            row_store[STORE_AW'((src_row & 1) * WIDTH_LIMIT + src_col)] = req.alpha_in;
            src_col++;
            if (src_col >= w) begin
                src_col = 0;
                src_row++;
            end
        end
    endtask

    always @(posedge i_clk) begin : p_track
        t_out want;
        if (!i_rst_n) begin
            width_reg = CFG_W'(1);
            height_reg = CFG_W'(1);
            for (int i = 0; i < 2 * WIDTH_LIMIT; i++) begin
                row_store[STORE_AW'(i)] = '0;
            end
            restart_frame();
            outline_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                checked_count++;
                if (outline_q.size() == 0) begin
                    report_mismatch($sformatf("result %p with nothing expected", i_out_data));
                end else begin
                    want = outline_q.pop_front();
                    if (i_out_data.gray_out !== want.gray_out) begin
                        report_mismatch($sformatf("gray_out got %0d want %0d",
                                                  i_out_data.gray_out, want.gray_out));
                    end
                    if (i_out_data.outline_alpha !== want.outline_alpha) begin
                        report_mismatch($sformatf("outline_alpha got %0d want %0d",
                                                  i_out_data.outline_alpha,
                                                  want.outline_alpha));
                    end
                    if (i_out_data.frame_last !== want.frame_last) begin
                        report_mismatch($sformatf("frame_last got %0b want %0b",
                                                  i_out_data.frame_last, want.frame_last));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data;
                    restart_frame();
                end else if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                    height_reg = i_cfg_data;
                    restart_frame();
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_in_data);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending <= outline_q.size();
        o_checked <= checked_count;
    end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import gaod_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);
    localparam int RANDOM_REQS = 80;
    localparam int LONG_HOLD   = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    t_in                  i_in_data;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;
    logic                 i_cfg_valid;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_cfg_ready;

    int mismatches;
    int pending;
    int checked;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit rx_hold_req = 1'b0;
    int sent_reqs = 0;
    int frame_reqs = 0;
    int frames = 0;

    glyph_alpha_outline_dilate u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    gaod_outline_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Timeout: requests or results stopped moving");
        $display("Regression FAIL");
        $finish;
    end

    // The receiver draws a pause before each result while rx_idle is set; one pause is a long hold that
    // lets the block fill up while requests keep coming.
    initial begin : p_receiver
        int pause;
        i_out_stall <= 1'b0;
        forever begin
            if (rx_hold_req) begin
                pause = LONG_HOLD;
                rx_hold_req = 1'b0;
            end else if (rx_idle) begin
                pause = $urandom_range(0, 6);
            end else begin
                pause = 0;
            end
            if (pause > 0) begin
                i_out_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        logic [ALPHA_W-1:0] a;
        case ($urandom_range(0, 3))
            0: a = '0;
            1: a = '1;
            default: a = ALPHA_W'($urandom);
        endcase
        return a;
    endfunction

    task automatic send_request(input logic kind, input logic [ALPHA_W-1:0] alpha);
        int  gap;
        t_in req;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        req.kind = kind;
        req.alpha_in = alpha;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_reqs++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A frame cut short gets no drain ticks; the next register write restarts it.
    task automatic stream_frame(input int w, input int h, input int pixels, input bit noisy);
        for (int p = 0; p < pixels; p++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                send_request(KIND_DRAIN, pick_alpha());
            end
            send_request(KIND_PIXEL, pick_alpha());
        end
        frame_reqs += pixels;
        if (pixels == w * h) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                send_request(KIND_PIXEL, pick_alpha());
            end
            for (int d = 0; d < 2 * (w + 2); d++) begin
                send_request(KIND_DRAIN, pick_alpha());
            end
            frame_reqs += 2 * (w + 2);
            frames++;
        end
    endtask

    initial begin : p_stimulus
        logic [ALPHA_W-1:0] pattern [6];
        int                 w;
        int                 h;
        int                 pixels;
        int                 k;
        bit                 first;
        pattern = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h00, 8'hfe};
        first = 1'b1;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One by one after reset: an early drain, the pixel, a late pixel, then the drain ticks.
        send_request(KIND_DRAIN, 8'h5a);
        send_request(KIND_PIXEL, 8'hff);
        send_request(KIND_PIXEL, 8'h00);
        for (int d = 0; d < 6; d++) begin
            send_request(KIND_DRAIN, 8'ha5);
        end
        frames++;

        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 2);
        for (int p = 0; p < 6; p++) begin
            send_request(KIND_PIXEL, pattern[p]);
        end
        for (int d = 0; d < 10; d++) begin
            send_request(KIND_DRAIN, pick_alpha());
        end
        frames++;

        frame_reqs = 0;
        while (frame_reqs < RANDOM_REQS) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            pixels = w * h;
            if (first) begin
                w = 12;
                h = 2;
                pixels = w * h;
                tx_idle = 1'b0;
                rx_hold_req = 1'b1;
                first = 1'b0;
            end else if (pixels > 1 && $urandom_range(0, 7) == 0) begin
                pixels = $urandom_range(1, w * h - 1);
            end
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
            stream_frame(w, h, pixels, 1'b1);
        end

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 2047);
        stream_frame(WIDTH_LIMIT, HEIGHT_LIMIT, 12, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 1024);
        write_reg(REG_IMAGE_HEIGHT, 0);
        stream_frame(WIDTH_LIMIT, 1, 12, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1024);
        stream_frame(1, HEIGHT_LIMIT, 12, 1'b0);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 3);
        write_reg(REG_UNUSED, $urandom_range(0, 2047));
        stream_frame(5, 3, 15, 1'b1);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (k = 0; k < 50000 && pending != 0; k++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Covered %0d requests and %0d results over %0d complete frames,",
                 sent_reqs, checked, frames);
        $display("sizes 1x1 up to 1024 wide or tall, zero and oversized sizes, cut frames.");
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
